// ----- sv/icr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_pkg: shared types and constants of the idle connection reaper
// Slot and count widths, event and result codes, the result struct that
// travels from the sequencer to the output register, and the link entry.
// ----------------------------------------------------------------------------
package icr_pkg;

	localparam int MAX_CONN    = 16;
	localparam int SLOT_W      = $clog2(MAX_CONN);
	localparam int CNT_W       = $clog2(MAX_CONN + 1);
	localparam int TIME_W      = 32;
	localparam int LIMIT_W     = 7;
	localparam int LIMIT_RESET = 10;
	localparam int MS_PER_S    = 1000;
	localparam int LIMIT_MS_W  = 17;

	typedef enum logic [1:0] {
		ACT_CONNECT    = 2'd0,
		ACT_DISCONNECT = 2'd1,
		ACT_MESSAGE    = 2'd2,
		ACT_TICK       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_DONE     = 2'd0,
		KIND_SHUTDOWN = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [SLOT_W-1:0] nxt;
		logic [SLOT_W-1:0] prv;
	} link_t;

endpackage

// ----- sv/icr_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_out_reg: result output register
// Holds one result item toward the downstream side and tells the
// sequencer when it can take the next one.
// ----------------------------------------------------------------------------
module icr_out_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  icr_pkg::result_t             res,
	output logic                         out_free,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic [1:0]                   kind,
	output logic [icr_pkg::SLOT_W-1:0]   out_slot,
	output logic                         last
);
	import icr_pkg::*;

	logic    valid_q;
	result_t data_q;

	// free when empty or the held item leaves this cycle
	assign out_free = !valid_q || !out_stall;

	// load a new item, or drop the held one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			data_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign kind      = data_q.kind;
	assign out_slot  = data_q.slot;
	assign last      = data_q.last;

endmodule

// ----- sv/icr_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_seq: list sequencer with link and time memories
// Keeps the least-recently-active list in a link memory (next and prev per
// slot) and a time memory, and steps connect, unlink, append and the tick
// walk through them one access per memory per cycle.
// ----------------------------------------------------------------------------
module icr_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  icr_pkg::action_t                  action,
	input  logic [icr_pkg::SLOT_W-1:0]        conn_slot,
	input  logic [icr_pkg::TIME_W-1:0]        now_ms,
	input  logic [icr_pkg::LIMIT_MS_W-1:0]    limit_ms,
	input  logic                              out_free,
	output icr_pkg::result_t                  res
);
	import icr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_U_EVAL,
		S_U_PREV,
		S_A_START,
		S_A_NEXT,
		S_A_PREV,
		S_W_RD,
		S_W_EVAL,
		S_FIN
	} state_t;

	state_t              state_q;
	logic [MAX_CONN-1:0] valid_q;
	logic [MAX_CONN-1:0] closing_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    visited_q;
	logic [SLOT_W-1:0]   cur_q;
	action_t             act_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TIME_W-1:0]   now_q;
	kind_t               kind_q;
	logic [SLOT_W-1:0]   p_q;
	logic [SLOT_W-1:0]   n_q;
	logic                was_tail_q;

	link_t               link_mem [MAX_CONN];
	logic [TIME_W-1:0]   time_mem [MAX_CONN];
	link_t               link_rdata_q;
	logic [TIME_W-1:0]   time_rdata_q;

	logic                lk_re;
	logic                lk_we_nxt;
	logic                lk_we_prv;
	logic [SLOT_W-1:0]   lk_addr;
	link_t               lk_wdata;
	logic                tm_re;
	logic                tm_we;
	logic [SLOT_W-1:0]   tm_addr;
	logic [TIME_W-1:0]   tm_wdata;

	logic [TIME_W-1:0]   age;
	logic                age_neg;
	logic                entry_idle;
	logic                shut_now;
	logic [CNT_W-1:0]    visited_inc;

	// age of the walked entry, taken as signed
	assign age         = now_q - time_rdata_q;
	assign age_neg     = age[TIME_W-1];
	assign entry_idle  = !age_neg && (age > TIME_W'(limit_ms));
	assign shut_now    = (state_q == S_W_EVAL) && entry_idle && !closing_q[cur_q];
	assign visited_inc = visited_q + CNT_W'(1);

	assign in_stall = (state_q != S_IDLE);

	// result toward the output register
	always_comb begin
		res.valid = (state_q == S_FIN) || shut_now;
		res.kind  = (state_q == S_FIN) ? kind_q : KIND_SHUTDOWN;
		res.slot  = (state_q == S_FIN) ? slot_q : cur_q;
		res.last  = (state_q == S_FIN);
	end

	// memory access for the current step
	always_comb begin
		lk_re     = 1'b0;
		lk_we_nxt = 1'b0;
		lk_we_prv = 1'b0;
		lk_addr   = cur_q;
		lk_wdata  = '0;
		tm_re     = 1'b0;
		tm_we     = 1'b0;
		tm_addr   = cur_q;
		tm_wdata  = now_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_CONNECT: begin
							tm_we    = !valid_q[conn_slot];
							tm_addr  = conn_slot;
							tm_wdata = now_ms;
						end
						ACT_DISCONNECT, ACT_MESSAGE: begin
							lk_re    = valid_q[conn_slot];
							lk_addr  = conn_slot;
							tm_we    = valid_q[conn_slot] && (action == ACT_MESSAGE);
							tm_addr  = conn_slot;
							tm_wdata = now_ms;
						end
						default: begin
						end
					endcase
				end
			end
			S_U_EVAL: begin
				lk_we_nxt    = (slot_q != head_q);
				lk_addr      = link_rdata_q.prv;
				lk_wdata.nxt = link_rdata_q.nxt;
			end
			S_U_PREV: begin
				lk_we_prv    = !was_tail_q;
				lk_addr      = n_q;
				lk_wdata.prv = p_q;
			end
			S_A_NEXT: begin
				lk_we_nxt    = 1'b1;
				lk_addr      = tail_q;
				lk_wdata.nxt = slot_q;
			end
			S_A_PREV: begin
				lk_we_prv    = 1'b1;
				lk_addr      = slot_q;
				lk_wdata.prv = tail_q;
			end
			S_W_RD: begin
				lk_re = 1'b1;
				tm_re = 1'b1;
			end
			S_W_EVAL: begin
				tm_we = age_neg;
			end
			default: begin
			end
		endcase
	end

	// link and time memories, registered read data
	always_ff @(posedge clk) begin
		if (lk_we_nxt) begin
			link_mem[lk_addr].nxt <= lk_wdata.nxt;
		end
		if (lk_we_prv) begin
			link_mem[lk_addr].prv <= lk_wdata.prv;
		end
		if (lk_re) begin
			link_rdata_q <= link_mem[lk_addr];
		end
		if (tm_we) begin
			time_mem[tm_addr] <= tm_wdata;
		end
		if (tm_re) begin
			time_rdata_q <= time_mem[tm_addr];
		end
	end

	// sequencer state, list registers and per-slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			closing_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (action)
							ACT_TICK: begin
								state_q <= (count_q == '0) ? S_FIN : S_W_RD;
							end
							ACT_CONNECT: begin
								if (valid_q[conn_slot]) begin
									state_q <= S_FIN;
								end else begin
									valid_q[conn_slot]   <= 1'b1;
									closing_q[conn_slot] <= 1'b0;
									state_q              <= S_A_START;
								end
							end
							default: begin
								state_q <= valid_q[conn_slot] ? S_U_EVAL : S_FIN;
							end
						endcase
					end
				end
				S_U_EVAL: begin
					if (count_q == CNT_W'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else begin
						if (slot_q == head_q) begin
							head_q <= link_rdata_q.nxt;
						end
						if (slot_q == tail_q) begin
							tail_q <= link_rdata_q.prv;
						end
					end
					count_q <= count_q - CNT_W'(1);
					state_q <= S_U_PREV;
				end
				S_U_PREV: begin
					if (act_q == ACT_DISCONNECT) begin
						valid_q[slot_q]   <= 1'b0;
						closing_q[slot_q] <= 1'b0;
						state_q           <= S_FIN;
					end else begin
						state_q <= S_A_START;
					end
				end
				S_A_START: begin
					if (count_q == '0) begin
						head_q  <= slot_q;
						tail_q  <= slot_q;
						count_q <= CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_A_NEXT;
					end
				end
				S_A_NEXT: begin
					state_q <= S_A_PREV;
				end
				S_A_PREV: begin
					tail_q  <= slot_q;
					count_q <= count_q + CNT_W'(1);
					state_q <= S_FIN;
				end
				S_W_RD: begin
					state_q <= S_W_EVAL;
				end
				S_W_EVAL: begin
					// hold while a shutdown item waits for the output
					if (!(shut_now && !out_free)) begin
						if (entry_idle) begin
							closing_q[cur_q] <= 1'b1;
						end
						if (!entry_idle && !age_neg) begin
							state_q <= S_FIN;
						end else if (visited_inc == count_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_W_RD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item fields and walk position
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					act_q     <= action;
					now_q     <= now_ms;
					cur_q     <= head_q;
					visited_q <= '0;
					slot_q    <= (action == ACT_TICK) ? '0 : conn_slot;
					if (action == ACT_TICK) begin
						kind_q <= KIND_DONE;
					end else if (action == ACT_CONNECT) begin
						kind_q <= valid_q[conn_slot] ? KIND_ERROR : KIND_DONE;
					end else begin
						kind_q <= valid_q[conn_slot] ? KIND_DONE : KIND_ERROR;
					end
				end
			end
			S_U_EVAL: begin
				p_q        <= link_rdata_q.prv;
				n_q        <= link_rdata_q.nxt;
				was_tail_q <= (slot_q == tail_q);
			end
			S_W_EVAL: begin
				if (!(shut_now && !out_free)) begin
					cur_q     <= link_rdata_q.nxt;
					visited_q <= visited_inc;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- sv/idle_connection_reaper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_connection_reaper_unit: idle connection reaper, top level
// Tracks connection slots in least-recently-active order and shuts down
// those idle beyond a programmable limit on each timer tick.
//
//   channel  signals                               direction
//   in       in_valid/in_stall, action,            input item
//            conn_slot, now_ms
//   out      out_valid/out_stall, kind,            result item
//            out_slot, last
//   cfg      cfg_we, cfg_wdata (idle limit, s)     register write
//
// One item at a time. After accept an error goes straight to the finish
// state; a disconnect unlinks (evaluate, then prev fix); a connect appends
// (start, next, prev), or only starts into an empty list; a message unlinks
// and then appends; a tick reads then evaluates each visited entry in the
// link and time memories. No clearing pass after reset: the list starts empty.
// A stalled output holds the walk; the input stalls until the last result
// of the current item has been loaded.
// ----------------------------------------------------------------------------
module idle_connection_reaper_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         action,
	input  logic [icr_pkg::SLOT_W-1:0]         conn_slot,
	input  logic [icr_pkg::TIME_W-1:0]         now_ms,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         kind,
	output logic [icr_pkg::SLOT_W-1:0]         out_slot,
	output logic                               last,
	input  logic                               cfg_we,
	input  logic [icr_pkg::LIMIT_W-1:0]        cfg_wdata
);
	import icr_pkg::*;

	logic [LIMIT_MS_W-1:0] limit_ms_q;
	result_t               res;
	logic                  out_free;

	// idle limit, kept in milliseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_ms_q <= LIMIT_MS_W'(LIMIT_RESET * MS_PER_S);
		end else if (cfg_we) begin
			limit_ms_q <= LIMIT_MS_W'(cfg_wdata) * LIMIT_MS_W'(MS_PER_S);
		end
	end

	icr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action_t'(action)),
		.conn_slot (conn_slot),
		.now_ms    (now_ms),
		.limit_ms  (limit_ms_q),
		.out_free  (out_free),
		.res       (res)
	);

	icr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.out_free  (out_free),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.kind      (kind),
		.out_slot  (out_slot),
		.last      (last)
	);

	// every accepted item keeps the input closed until it finishes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input open right after an accepted item");

	// results are only produced while an item is in work
	a_no_result_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !res.valid)
		else $error("result produced with no item in work");

	// a shutdown is never the final result of an item
	a_shutdown_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((kind == KIND_SHUTDOWN) && last))
		else $error("shutdown item marked last");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for idle_connection_reaper_unit
// A queue of connection events feeds a clocked driver; every accepted item
// runs through an LRU list predictor kept here, and a clocked monitor
// compares each result item against the oldest predicted one. Phases vary
// the idle limit (reset value, 0, 127 and two others) and the amount of
// sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
	import icr_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 59;

	typedef struct {
		action_t           act;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now;
		bit                drain;
	} conn_event_t;

	typedef struct {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} due_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          action = '0;
	logic [SLOT_W-1:0]   conn_slot = '0;
	logic [TIME_W-1:0]   now_ms = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          kind;
	logic [SLOT_W-1:0]   out_slot;
	logic                last;
	logic                cfg_we = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata = '0;

	conn_event_t         event_queue[$];
	conn_event_t         cur_event;
	due_result_t         due_results[$];
	int                  err_count = 0;
	int                  cycle_count = 0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;

	// predicted block state
	bit                  rec_valid   [MAX_CONN];
	bit                  rec_closing [MAX_CONN];
	bit [TIME_W-1:0]     rec_time    [MAX_CONN];
	bit [SLOT_W-1:0]     rec_next    [MAX_CONN];
	bit [SLOT_W-1:0]     rec_prev    [MAX_CONN];
	bit [SLOT_W-1:0]     lru_head = '0;
	bit [SLOT_W-1:0]     lru_tail = '0;
	int                  lru_count = 0;
	logic [LIMIT_W-1:0]  idle_limit = LIMIT_W'(LIMIT_RESET);

	// stimulus generator view of which slots are open
	bit                  gen_open [MAX_CONN];
	logic [TIME_W-1:0]   gen_now = '0;
	int                  gen_count = 0;

	idle_connection_reaper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.conn_slot (conn_slot),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_slot  (out_slot),
		.last      (last),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	function automatic void due_push(kind_t k, logic [SLOT_W-1:0] s, logic l);
		due_result_t r;
		r.kind = k;
		r.slot = s;
		r.last = l;
		due_results = {due_results, r};
	endfunction

	function automatic void lru_append(logic [SLOT_W-1:0] s);
		if (lru_count == 0) begin
			lru_head = s;
		end else begin
			rec_next[lru_tail] = s;
			rec_prev[s] = lru_tail;
		end
		lru_tail = s;
		lru_count++;
	endfunction

	// Advance the predicted list by one event and queue the results it causes
	task automatic apply_event(conn_event_t ev);
		logic [SLOT_W-1:0]     s;
		logic [SLOT_W-1:0]     p;
		logic [SLOT_W-1:0]     n;
		logic [TIME_W-1:0]     age;
		logic [LIMIT_MS_W-1:0] lim_ms;
		int                    visited;
		bit                    stop;
		bit                    bad;
		s = ev.slot;
		if (ev.act == ACT_TICK) begin
			lim_ms = LIMIT_MS_W'(idle_limit * MS_PER_S);
			s = lru_head;
			visited = 0;
			stop = 0;
			// walk from the oldest entry until one is neither idle nor negative
			while (!stop && visited < lru_count && visited < MAX_CONN) begin
				age = ev.now - rec_time[s];
				if (!age[TIME_W-1] && age > lim_ms) begin
					if (!rec_closing[s]) begin
						due_push(KIND_SHUTDOWN, s, 1'b0);
						rec_closing[s] = 1'b1;
					end
				end else if (age[TIME_W-1]) begin
					rec_time[s] = ev.now;
				end else begin
					stop = 1;
				end
				if (!stop) begin
					s = rec_next[s];
					visited++;
				end
			end
			due_push(KIND_DONE, '0, 1'b1);
		end else begin
			bad = (ev.act == ACT_CONNECT) ? rec_valid[s] : !rec_valid[s];
			if (bad) begin
				due_push(KIND_ERROR, s, 1'b1);
			end else begin
				if (ev.act == ACT_CONNECT) begin
					rec_valid[s] = 1'b1;
					rec_closing[s] = 1'b0;
					rec_time[s] = ev.now;
					lru_append(s);
				end else begin
					// unlink, then drop or move to the tail
					p = rec_prev[s];
					n = rec_next[s];
					if (s == lru_head) lru_head = n;
					else rec_next[p] = n;
					if (s == lru_tail) lru_tail = p;
					else rec_prev[n] = p;
					lru_count--;
					if (lru_count == 0) begin
						lru_head = '0;
						lru_tail = '0;
					end
					if (ev.act == ACT_DISCONNECT) begin
						rec_valid[s] = 1'b0;
						rec_closing[s] = 1'b0;
					end else begin
						rec_time[s] = ev.now;
						lru_append(s);
					end
				end
				due_push(KIND_DONE, s, 1'b1);
			end
		end
	endtask

	// Queue one event and track the open slots it leaves behind
	task automatic add_event(action_t a, logic [SLOT_W-1:0] s, logic [TIME_W-1:0] t,
			bit drain);
		conn_event_t ev;
		ev.act = a;
		ev.slot = s;
		ev.now = t;
		ev.drain = drain;
		event_queue = {event_queue, ev};
		gen_count++;
		if (a == ACT_CONNECT) gen_open[s] = 1'b1;
		else if (a == ACT_DISCONNECT) gen_open[s] = 1'b0;
	endtask

	function automatic int pick_slot(bit want_open);
		int start;
		int idx;
		start = $urandom_range(MAX_CONN - 1);
		for (int i = 0; i < MAX_CONN; i++) begin
			idx = (start + i) % MAX_CONN;
			if (gen_open[idx] == want_open) return idx;
		end
		return -1;
	endfunction

	// Mostly well-formed event streams with a share of noise and broken ones
	task automatic gen_random(int n, int lim_ms);
		int    target;
		int    r;
		int    s;
		bit    drain;
		target = gen_count + n;
		while (gen_count < target) begin
			r = $urandom_range(99);
			drain = ($urandom_range(24) == 0);
			if (r < 8) begin
				add_event(action_t'($urandom_range(3)), SLOT_W'($urandom_range(MAX_CONN - 1)),
					$urandom(), drain);
			end else if (r < 13) begin
				s = pick_slot(1);
				if (s >= 0 && $urandom_range(1)) begin
					add_event(ACT_CONNECT, SLOT_W'(s), gen_now, drain);
				end else begin
					s = pick_slot(0);
					if (s >= 0)
						add_event(action_t'($urandom_range(1) ? ACT_DISCONNECT : ACT_MESSAGE),
							SLOT_W'(s), gen_now, drain);
				end
			end else if (r < 16) begin
				// fill every slot, then jump past the limit so one tick reaps all
				if ($urandom_range(1)) begin
					s = pick_slot(1);
					while (s >= 0) begin
						add_event(ACT_DISCONNECT, SLOT_W'(s), gen_now, 1'b0);
						s = pick_slot(1);
					end
				end
				s = pick_slot(0);
				while (s >= 0) begin
					gen_now += $urandom_range(40);
					add_event(ACT_CONNECT, SLOT_W'(s), gen_now, 1'b0);
					s = pick_slot(0);
				end
				gen_now += lim_ms + $urandom_range(100, 2000);
				add_event(ACT_TICK, SLOT_W'($urandom_range(MAX_CONN - 1)), gen_now, drain);
			end else begin
				gen_now += $urandom_range(lim_ms / 4 + 50);
				r = $urandom_range(99);
				if (r < 62) begin
					if (r < 28) s = pick_slot(0);
					else s = pick_slot(1);
					if (s < 0) begin
						r = (r < 28) ? 40 : 0;
						s = pick_slot(r < 28 ? 0 : 1);
					end
					if (r < 28) add_event(ACT_CONNECT, SLOT_W'(s), gen_now, drain);
					else if (r < 50) add_event(ACT_MESSAGE, SLOT_W'(s), gen_now, drain);
					else add_event(ACT_DISCONNECT, SLOT_W'(s), gen_now, drain);
				end else begin
					r = $urandom_range(99);
					if (r < 35) gen_now += lim_ms + $urandom_range(1, 3000);
					else if (r < 43) gen_now -= $urandom_range(1, 60000);
					add_event(ACT_TICK, SLOT_W'($urandom_range(MAX_CONN - 1)), gen_now, drain);
				end
			end
		end
	endtask

	// Wait for the block to go idle, then write the idle limit
	task automatic write_limit(logic [LIMIT_W-1:0] v);
		while (event_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		idle_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drive the next item; hold it while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) apply_event(cur_event);
			if (!in_valid || !in_stall) begin
				if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct
						&& !(event_queue[0].drain && due_results.size() != 0)) begin
					cur_event = event_queue.pop_front();
					in_valid <= 1'b1;
					action <= cur_event.act;
					conn_slot <= cur_event.slot;
					now_ms <= cur_event.now;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted result item against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unpredicted result kind %0d slot %0d last %0b",
						kind, out_slot, last));
				end else if ({kind, out_slot, last} !== {due_results[0].kind,
						due_results[0].slot, due_results[0].last}) begin
					report_mismatch($sformatf(
						"got kind %0d slot %0d last %0b, want kind %0d slot %0d last %0b",
						kind, out_slot, last, due_results[0].kind, due_results[0].slot,
						due_results[0].last));
					void'(due_results.pop_front());
				end else begin
					void'(due_results.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("idle_connection_reaper_unit verification failed");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: errors, boundary age, closing entries, negative ages, unlinks
		add_event(ACT_TICK, 4'hA, 32'd0, 1'b0);
		add_event(ACT_DISCONNECT, 4'd5, 32'd0, 1'b0);
		add_event(ACT_MESSAGE, 4'd5, 32'd0, 1'b0);
		add_event(ACT_CONNECT, 4'd0, 32'd0, 1'b0);
		add_event(ACT_CONNECT, 4'd15, 32'd100, 1'b0);
		add_event(ACT_CONNECT, 4'd0, 32'd150, 1'b0);
		add_event(ACT_CONNECT, 4'd7, 32'd200, 1'b0);
		add_event(ACT_MESSAGE, 4'd0, 32'd300, 1'b0);
		add_event(ACT_TICK, 4'd0, 32'd10100, 1'b0);
		add_event(ACT_TICK, 4'd0, 32'd10101, 1'b0);
		add_event(ACT_TICK, 4'd0, 32'd20000, 1'b0);
		add_event(ACT_MESSAGE, 4'd15, 32'd20500, 1'b0);
		add_event(ACT_TICK, 4'd3, 32'hFFFF_FFFF, 1'b0);
		add_event(ACT_TICK, 4'd0, 32'd20000, 1'b0);
		add_event(ACT_DISCONNECT, 4'd0, 32'd20000, 1'b0);
		add_event(ACT_CONNECT, 4'd0, 32'd20000, 1'b0);
		add_event(ACT_TICK, 4'd0, 32'd30001, 1'b0);
		add_event(ACT_DISCONNECT, 4'd7, 32'd30001, 1'b0);
		add_event(ACT_DISCONNECT, 4'd0, 32'd30001, 1'b0);
		add_event(ACT_DISCONNECT, 4'd15, 32'd30001, 1'b0);
		add_event(ACT_CONNECT, 4'd9, 32'hFFFF_FFFF, 1'b0);
		add_event(ACT_TICK, 4'd0, 32'd0, 1'b0);
		add_event(ACT_MESSAGE, 4'd9, 32'h8000_0000, 1'b0);
		add_event(ACT_DISCONNECT, 4'd9, 32'h8000_0000, 1'b1);
		gen_now = 32'd40000;

		// limit zero, no idling
		write_limit(7'd0);
		@(negedge clk);
		gen_random(PHASE_ITEMS, 0);

		// largest limit, sender idles
		write_limit(7'd127);
		@(negedge clk);
		send_idle_pct = 58;
		gen_random(PHASE_ITEMS, 127000);

		// short limit, receiver stalls, time wraps through zero
		write_limit(7'd3);
		@(negedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 58;
		gen_now = 32'hFFFE_0000;
		gen_random(PHASE_ITEMS, 3000);

		// mid limit, both sides idle
		write_limit(7'd20);
		@(negedge clk);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		gen_random(PHASE_ITEMS, 20000);

		while (event_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("idle_connection_reaper_unit verification clean");
		end else begin
			$display("idle_connection_reaper_unit verification failed");
		end
		$finish;
	end

endmodule
